// ===== sv/egcd_pkg.sv =====
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared constants and the sequencer state type of the extended gcd core.
// ----------------------------------------------------------------------------
package egcd_pkg;

	localparam int WORD_BITS_DEF = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPD,
		ST_FIN,
		ST_MODLD,
		ST_MFIX,
		ST_OUT
	} egcd_state_t;

endpackage

// ===== sv/extended_gcd_mod_inverse_core.sv =====
// ----------------------------------------------------------------------------
// extended_gcd_mod_inverse_core
// Extended Euclid with truncating division and modular inverse of a_value
// modulo b_value, built around one shift-subtract divider stepped per cycle.
// ----------------------------------------------------------------------------
// channel  | handshake      | fields
// ---------+----------------+-----------------------------------------------
// request  | start / busy   | a_value, b_value
// result   | done (1 cycle) | gcd_value, coef_x, coef_y, inverse_value,
//          |                | inverse_valid
//
// each euclid step runs the check state, the divider over every quotient bit
// and the update state; the inverse then runs the fin and load states and,
// for a positive modulus, one more division and the fix state. an operand equal
// to the most negative word goes straight from idle to the result state.
// arst_n clears the sequencer and the strobe; datapath registers keep no reset.
// results cannot be stalled: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module extended_gcd_mod_inverse_core
	import egcd_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [WORD_BITS-1:0] a_value,
	input  logic [WORD_BITS-1:0] b_value,
	output logic                 done,
	output logic [WORD_BITS-2:0] gcd_value,
	output logic [WORD_BITS-1:0] coef_x,
	output logic [WORD_BITS-1:0] coef_y,
	output logic [WORD_BITS-2:0] inverse_value,
	output logic                 inverse_valid
);

	localparam int W  = WORD_BITS;
	localparam int CW = $clog2(W);

	localparam logic [W-1:0]  MIN_WORD = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0]  ONE_WORD = {{(W-1){1'b0}}, 1'b1};
	localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

	egcd_state_t state_q, state_d;

	logic [W-1:0]   a_q, b_q, m_q;
	logic [W-1:0]   x_q, y_q, x1_q, y1_q;
	logic [W-1:0]   rem_q, dvd_q, dsr_q, accx_q, accy_q;
	logic [CW-1:0]  cnt_q;
	logic           mode_q;
	logic [W-2:0]   gcd_q, inv_q;
	logic           valid_q;

	// divider step
	logic [W-1:0]   shifted;
	logic [W:0]     diff;
	logic           qbit;
	logic [W-1:0]   rem_nx;

	logic           in_min, last_bit, b_zero, qneg, fin_neg, m_pos;
	logic [W-1:0]   abs_a, abs_b, abs_x;
	logic [W-1:0]   nx, ny, nb, inv_full;

	assign shifted  = {rem_q[W-2:0], dvd_q[W-1]};
	assign diff     = {1'b0, shifted} - {1'b0, dsr_q};
	assign qbit     = ~diff[W];
	assign rem_nx   = qbit ? diff[W-1:0] : shifted;

	assign in_min   = (a_value == MIN_WORD) || (b_value == MIN_WORD);
	assign last_bit = (cnt_q == CNT_LAST);
	assign b_zero   = (b_q == '0);
	assign qneg     = a_q[W-1] ^ b_q[W-1];
	assign fin_neg  = (a_q == '0) || a_q[W-1];
	assign m_pos    = ~m_q[W-1] && (m_q != '0);

	assign abs_a    = a_q[W-1] ? -a_q : a_q;
	assign abs_b    = b_q[W-1] ? -b_q : b_q;
	assign abs_x    = x_q[W-1] ? -x_q : x_q;

	// accumulators hold |q| times x1 and y1, sign applied here
	assign nx       = qneg ? x_q + accx_q : x_q - accx_q;
	assign ny       = qneg ? y_q + accy_q : y_q - accy_q;
	assign nb       = a_q[W-1] ? -rem_q : rem_q;
	assign inv_full = (x_q[W-1] && (rem_q != '0)) ? m_q - rem_q : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = in_min ? ST_OUT : ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = b_zero ? ST_FIN : ST_DIV;
			end
			ST_DIV: begin
				if (last_bit) begin
					state_d = mode_q ? ST_MFIX : ST_UPD;
				end
			end
			ST_UPD:   state_d = ST_CHECK;
			ST_FIN:   state_d = ST_MODLD;
			ST_MODLD: state_d = m_pos ? ST_DIV : ST_OUT;
			ST_MFIX:  state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					a_q     <= a_value;
					b_q     <= b_value;
					m_q     <= b_value;
					x_q     <= in_min ? '0 : ONE_WORD;
					y_q     <= '0;
					x1_q    <= '0;
					y1_q    <= ONE_WORD;
					gcd_q   <= '0;
					inv_q   <= '0;
					valid_q <= 1'b0;
					mode_q  <= 1'b0;
				end
			end
			ST_CHECK: begin
				rem_q  <= '0;
				dvd_q  <= abs_a;
				dsr_q  <= abs_b;
				accx_q <= '0;
				accy_q <= '0;
				cnt_q  <= '0;
			end
			ST_DIV: begin
				rem_q  <= rem_nx;
				dvd_q  <= {dvd_q[W-2:0], 1'b0};
				accx_q <= {accx_q[W-2:0], 1'b0} + (qbit ? x1_q : '0);
				accy_q <= {accy_q[W-2:0], 1'b0} + (qbit ? y1_q : '0);
				cnt_q  <= cnt_q + 1'b1;
			end
			ST_UPD: begin
				x_q  <= x1_q;
				y_q  <= y1_q;
				x1_q <= nx;
				y1_q <= ny;
				a_q  <= b_q;
				b_q  <= nb;
			end
			ST_FIN: begin
				if (fin_neg) begin
					x_q <= -x_q;
					y_q <= -y_q;
				end
				gcd_q <= abs_a[W-2:0];
			end
			ST_MODLD: begin
				rem_q  <= '0;
				dvd_q  <= abs_x;
				dsr_q  <= m_q;
				accx_q <= '0;
				accy_q <= '0;
				cnt_q  <= '0;
				mode_q <= 1'b1;
			end
			ST_MFIX: begin
				inv_q   <= inv_full[W-2:0];
				valid_q <= (gcd_q == ONE_WORD[W-2:0]);
			end
			default: begin
			end
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = (state_q == ST_OUT);
	assign gcd_value     = gcd_q;
	assign coef_x        = x_q;
	assign coef_y        = y_q;
	assign inverse_value = inv_q;
	assign inverse_valid = valid_q;

endmodule

// ===== sv/egcd_checker.sv =====
// ----------------------------------------------------------------------------
// egcd_checker
// Port-level checks on the extended gcd core, bound into the core module.
// ----------------------------------------------------------------------------
module egcd_checker
	import egcd_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic [WORD_BITS-2:0] gcd_value,
	input logic                 inverse_valid
);

	// a request is taken only when idle, and the core goes busy at once
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted without going busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// busy drops only right after the result has been shown
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

	a_inv_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		done && inverse_valid |-> gcd_value == {{(WORD_BITS-2){1'b0}}, 1'b1})
		else $error("inverse flagged valid with gcd not one");

endmodule

bind extended_gcd_mod_inverse_core egcd_checker #(
	.WORD_BITS(WORD_BITS)
) u_egcd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.gcd_value    (gcd_value),
	.inverse_valid(inverse_valid)
);
